@@ sv/vfpm_pkg.sv @@
// ----------------------------------------------------------------------------
// vfpm_pkg
// Shared types and constants of the video frame PSNR meter.
// ----------------------------------------------------------------------------
package vfpm_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int SAMPLE_W  = 8;
	localparam int SQ_W      = 16;
	localparam int PSNR_W    = 16;
	localparam int OUT_SUM_W = 40;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 3 * PSNR_W + 3 * OUT_SUM_W;

	localparam int RST_WIDTH  = 1920;
	localparam int RST_HEIGHT = 1080;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int LOG_FRAC  = 24;
	localparam int LOG_BIT_W = 5;
	localparam int K_FRAC    = 28;
	localparam int K_W       = 30;
	localparam logic [K_W-1:0] TEN_LOG10_2 = 30'd808071242;
	localparam logic [15:0] PEAK_SQ = 16'd65025;
	localparam logic [PSNR_W-1:0] PSNR_MAX = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		LAYOUT_UYVY = 2'd0,
		LAYOUT_420  = 2'd1,
		LAYOUT_422  = 2'd2,
		LAYOUT_444  = 2'd3
	} layout_t;

	typedef enum logic [1:0] {
		CH_Y  = 2'd0,
		CH_CB = 2'd1,
		CH_CR = 2'd2
	} ch_t;

	typedef struct packed {
		logic            last;
		ch_t             ch;
		logic [SQ_W-1:0] sq;
	} item_t;

	typedef struct packed {
		logic                 identical;
		logic [OUT_SUM_W-1:0] cr_sum;
		logic [OUT_SUM_W-1:0] cb_sum;
		logic [OUT_SUM_W-1:0] luma_sum;
		logic [PSNR_W-1:0]    cr_psnr;
		logic [PSNR_W-1:0]    cb_psnr;
		logic [PSNR_W-1:0]    luma_psnr;
	} result_t;

endpackage

@@ sv/vfpm_front.sv @@
// ----------------------------------------------------------------------------
// vfpm_front
// Accepts sample pairs, sorts each into Y, Cb or Cr by frame position,
// squares the difference and marks the last byte of the frame.
// ----------------------------------------------------------------------------
module vfpm_front #(
	parameter int P_W   = 25,
	parameter int POS_W = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [vfpm_pkg::SAMPLE_W-1:0] ref_sample,
	input  logic [vfpm_pkg::SAMPLE_W-1:0] test_sample,
	input  vfpm_pkg::layout_t         layout,
	input  logic [P_W-1:0]            p,
	input  logic [P_W-1:0]            c,
	input  logic [POS_W-1:0]          total,
	input  logic                      q_ready,
	output logic                      q_push,
	output vfpm_pkg::item_t           q_item
);
	import vfpm_pkg::*;

	logic [POS_W-1:0]    pos_q;
	logic [POS_W:0]      pos_inc;
	logic [POS_W:0]      luma_end;
	logic [POS_W:0]      cb_end;
	logic [SAMPLE_W-1:0] abs_diff;
	logic                last;
	ch_t                 ch;

	assign in_ready = q_ready;
	assign q_push   = in_valid & q_ready;

	always_comb begin
		pos_inc  = {1'b0, pos_q} + (POS_W + 1)'(1);
		luma_end = (POS_W + 1)'(p);
		cb_end   = (POS_W + 1)'(p) + (POS_W + 1)'(c);
		last     = (pos_inc >= {1'b0, total});
		abs_diff = (test_sample >= ref_sample) ? (test_sample - ref_sample)
		                                       : (ref_sample - test_sample);
		if (layout == LAYOUT_UYVY) begin
			case (pos_q[1:0])
				2'd0: ch = CH_CB;
				2'd2: ch = CH_CR;
				default: ch = CH_Y;
			endcase
		end else if ({1'b0, pos_q} < luma_end) begin
			ch = CH_Y;
		end else if ({1'b0, pos_q} < cb_end) begin
			ch = CH_CB;
		end else begin
			ch = CH_CR;
		end
		q_item.last = last;
		q_item.ch   = ch;
		q_item.sq   = SQ_W'(abs_diff) * SQ_W'(abs_diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= last ? '0 : pos_inc[POS_W-1:0];
		end
	end

endmodule

@@ sv/vfpm_queue.sv @@
// ----------------------------------------------------------------------------
// vfpm_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module vfpm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vfpm_pkg::item_t push_item,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output vfpm_pkg::item_t pop_item
);
	import vfpm_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign ready    = (cnt_q != QCNT_W'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/vfpm_psnr.sv @@
// ----------------------------------------------------------------------------
// vfpm_psnr
// Sequential PSNR unit: per channel, two fixed-point log2 evaluations by
// shift normalization and repeated squaring, then scaling to dB.
// ----------------------------------------------------------------------------
module vfpm_psnr #(
	parameter int ACC_W     = 40,
	parameter int CNT_W     = 25,
	parameter int FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ACC_W-1:0]            sums [3],
	input  logic [CNT_W-1:0]            counts [3],
	output logic                        done,
	output logic [vfpm_pkg::PSNR_W-1:0] res [3]
);
	import vfpm_pkg::*;

	localparam int LX_W   = (ACC_W > 32) ? ACC_W : 32;
	localparam int E_W    = $clog2(LX_W);
	localparam int LOG_W  = E_W + LOG_FRAC;
	localparam int PROD_W = LOG_W + K_W;
	localparam int RND_W  = PROD_W + 17;
	localparam int R      = LOG_FRAC + K_FRAC - FRAC_BITS;

	typedef enum logic [6:0] {
		P_IDLE  = 7'b0000001,
		P_PREP  = 7'b0000010,
		P_NORM  = 7'b0000100,
		P_SQR   = 7'b0001000,
		P_LOG   = 7'b0010000,
		P_ROUND = 7'b0100000,
		P_DONE  = 7'b1000000
	} pstate_t;

	pstate_t               st_q;
	logic [1:0]            idx_q;
	logic                  second_q;
	logic [LX_W-1:0]       x_q;
	logic [E_W-1:0]        e_q;
	logic [31:0]           m_q;
	logic [LOG_FRAC-1:0]   frac_q;
	logic [LOG_BIT_W-1:0]  bit_q;
	logic [LOG_W-1:0]      la_q;
	logic [PROD_W-1:0]     prod_q;
	logic [PSNR_W-1:0]     res_q [3];

	logic [CNT_W+15:0]     a_full;
	logic [63:0]           sq_full;
	logic [32:0]           sq_top;
	logic [LOG_W-1:0]      log_now;
	logic [LOG_W-1:0]      diff;
	logic [RND_W-1:0]      rnd;
	logic [RND_W-1:0]      scaled;
	logic [PSNR_W-1:0]     sat;
	logic                  last_ch;

	assign done = (st_q == P_DONE);
	assign res  = res_q;

	always_comb begin
		a_full  = (CNT_W + 16)'(counts[idx_q]) * (CNT_W + 16)'(PEAK_SQ);
		sq_full = 64'(m_q) * 64'(m_q);
		sq_top  = sq_full[63:31];
		log_now = {e_q, frac_q};
		diff    = la_q - log_now;
		rnd     = RND_W'(prod_q) + (RND_W'(1) << (R - 1));
		scaled  = rnd >> R;
		sat     = (scaled > RND_W'(PSNR_MAX)) ? PSNR_MAX : scaled[PSNR_W-1:0];
		last_ch = (idx_q == 2'(CH_CR));
	end

	always_ff @(posedge clk) begin
		case (st_q)
			P_PREP: begin
				x_q      <= LX_W'(a_full);
				e_q      <= E_W'(LX_W - 1);
				second_q <= 1'b0;
			end
			P_NORM: begin
				if (x_q[LX_W-1]) begin
					m_q    <= x_q[LX_W-1 -: 32];
					frac_q <= '0;
					bit_q  <= LOG_BIT_W'(LOG_FRAC - 1);
				end else begin
					x_q <= {x_q[LX_W-2:0], 1'b0};
					e_q <= e_q - E_W'(1);
				end
			end
			P_SQR: begin
				if (sq_top[32]) begin
					m_q           <= sq_top[32:1];
					frac_q[bit_q] <= 1'b1;
				end else begin
					m_q <= sq_top[31:0];
				end
				bit_q <= bit_q - LOG_BIT_W'(1);
			end
			P_LOG: begin
				if (!second_q) begin
					la_q     <= log_now;
					x_q      <= LX_W'(sums[idx_q]);
					e_q      <= E_W'(LX_W - 1);
					second_q <= 1'b1;
				end else begin
					prod_q <= PROD_W'(diff) * PROD_W'(TEN_LOG10_2);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= P_IDLE;
			idx_q <= '0;
		end else begin
			case (st_q)
				P_IDLE: begin
					if (start) begin
						idx_q <= '0;
						st_q  <= P_PREP;
					end
				end
				P_PREP: begin
					if (sums[idx_q] == '0 || counts[idx_q] == '0) begin
						res_q[idx_q] <= (sums[idx_q] == '0) ? PSNR_MAX : '0;
						idx_q        <= idx_q + 2'd1;
						st_q         <= last_ch ? P_DONE : P_PREP;
					end else begin
						st_q <= P_NORM;
					end
				end
				P_NORM: begin
					if (x_q[LX_W-1]) begin
						st_q <= P_SQR;
					end
				end
				P_SQR: begin
					if (bit_q == '0) begin
						st_q <= P_LOG;
					end
				end
				P_LOG: begin
					if (!second_q) begin
						st_q <= P_NORM;
					end else if (la_q <= log_now) begin
						res_q[idx_q] <= '0;
						idx_q        <= idx_q + 2'd1;
						st_q         <= last_ch ? P_DONE : P_PREP;
					end else begin
						st_q <= P_ROUND;
					end
				end
				P_ROUND: begin
					res_q[idx_q] <= sat;
					idx_q        <= idx_q + 2'd1;
					st_q         <= last_ch ? P_DONE : P_PREP;
				end
				P_DONE: begin
					st_q <= P_IDLE;
				end
				default: begin
					st_q <= P_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/vfpm_back.sv @@
// ----------------------------------------------------------------------------
// vfpm_back
// Drains the request queue into the per-channel sums; at the end of a frame
// snapshots sums and channel counts, runs the PSNR unit and holds the result.
// ----------------------------------------------------------------------------
module vfpm_back #(
	parameter int ACC_W     = 40,
	parameter int P_W       = 25,
	parameter int FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  vfpm_pkg::item_t   q_item,
	output logic              q_pop,
	input  vfpm_pkg::layout_t layout,
	input  logic [P_W-1:0]    p,
	input  logic [P_W-1:0]    c,
	output logic              out_valid,
	input  logic              out_ready,
	output vfpm_pkg::result_t out_res
);
	import vfpm_pkg::*;

	typedef enum logic [1:0] {
		B_ACC  = 2'b01,
		B_CALC = 2'b10
	} bstate_t;

	bstate_t          st_q;
	logic             start_q;
	logic             out_valid_q;
	result_t          res_q;
	logic [ACC_W-1:0] acc_q [3];
	logic [ACC_W-1:0] sum_q [3];
	logic [P_W-1:0]   cnt_q [3];
	logic [P_W-1:0]   cnt_now [3];
	logic [P_W+1:0]   two_p;
	logic [P_W+1:0]   nb_w;
	logic [P_W+1:0]   nr_w;
	logic [63:0]      sum64 [3];
	logic             done;
	logic [PSNR_W-1:0] psnr [3];

	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign q_pop     = q_valid && (st_q == B_ACC) && (!q_item.last || !out_valid_q);

	always_comb begin
		two_p = {1'b0, p, 1'b0};
		nb_w  = (two_p + (P_W + 2)'(3)) >> 2;
		nr_w  = (two_p + (P_W + 2)'(1)) >> 2;
		cnt_now[0] = p;
		if (layout == LAYOUT_UYVY) begin
			cnt_now[1] = nb_w[P_W-1:0];
			cnt_now[2] = nr_w[P_W-1:0];
		end else begin
			cnt_now[1] = c;
			cnt_now[2] = c;
		end
		for (int i = 0; i < 3; i++) begin
			sum64[i] = 64'(sum_q[i]);
		end
	end

	vfpm_psnr #(
		.ACC_W     (ACC_W),
		.CNT_W     (P_W),
		.FRAC_BITS (FRAC_BITS)
	) u_psnr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.sums   (sum_q),
		.counts (cnt_q),
		.done   (done),
		.res    (psnr)
	);

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= acc_q[i] + ((q_item.ch == ch_t'(2'(i))) ? ACC_W'(q_item.sq)
				                                                    : '0);
				cnt_q[i] <= cnt_now[i];
			end
		end
		if (done) begin
			res_q.luma_psnr <= psnr[0];
			res_q.cb_psnr   <= psnr[1];
			res_q.cr_psnr   <= psnr[2];
			res_q.luma_sum  <= sum64[0][OUT_SUM_W-1:0];
			res_q.cb_sum    <= sum64[1][OUT_SUM_W-1:0];
			res_q.cr_sum    <= sum64[2][OUT_SUM_W-1:0];
			res_q.identical <= (sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_ACC;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_ACC: begin
					if (q_pop) begin
						if (q_item.last) begin
							for (int i = 0; i < 3; i++) begin
								acc_q[i] <= '0;
							end
							start_q <= 1'b1;
							st_q    <= B_CALC;
						end else begin
							for (int i = 0; i < 3; i++) begin
								if (q_item.ch == ch_t'(2'(i))) begin
									acc_q[i] <= acc_q[i] + ACC_W'(q_item.sq);
								end
							end
						end
					end
				end
				B_CALC: begin
					if (done) begin
						out_valid_q <= 1'b1;
						st_q        <= B_ACC;
					end
				end
				default: begin
					st_q <= B_ACC;
				end
			endcase
		end
	end

endmodule

@@ sv/video_frame_psnr_meter_unit.sv @@
// ----------------------------------------------------------------------------
// video_frame_psnr_meter_unit
// Per-channel PSNR meter for YUV frames (packed UYVY or planar 4:2:0,
// 4:2:2, 4:4:4).
//
// Feed one reference/test byte pair per request on s_axis, in frame order.
// Program layout, frame_width and frame_height through the cfg port while
// the meter is idle. After the last byte of a frame one result comes out on
// m_axis: three PSNR values in dB (unsigned, PSNR_FRAC_BITS fraction bits,
// all ones for a channel with no error) and three squared-error sums;
// tuser flags a frame with no error at all.
// Throughput: one byte per cycle within a frame while the four-entry queue
// between classifier and accumulators has room. While the PSNR unit runs
// on a finished frame, the queue fills and s_axis stalls.
// Reset clears the position, the sums and the output valid flag and loads
// the register defaults (UYVY, 1920 x 1080). If m_axis is stalled, bytes of
// the next frame keep being summed; only the next frame end waits.
// ----------------------------------------------------------------------------
module video_frame_psnr_meter_unit #(
	parameter int MAX_DIM        = 4096,
	parameter int PSNR_FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vfpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vfpm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// ref_sample[7:0], test_sample[15:8]
	input  logic [vfpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// luma_psnr, cb_psnr, cr_psnr (16 each), luma_sq_sum, cb_sq_sum,
	// cr_sq_sum (40 each)
	output logic [vfpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// frames_identical
	output logic [0:0]                         m_axis_tuser
);
	import vfpm_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int P_W   = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int POS_W = $clog2(3 * MAX_DIM * MAX_DIM + 1);
	localparam int ACC_W = $clog2(64'd65025 * MAX_DIM * MAX_DIM + 64'd1);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (v > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(v);
	endfunction

	layout_t          layout_q;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [P_W-1:0]   p_q;
	logic [P_W-1:0]   c;
	logic [POS_W-1:0] total;

	logic             q_ready;
	logic             q_push;
	item_t            push_item;
	logic             q_valid;
	logic             q_pop;
	item_t            pop_item;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_UYVY;
			w_q      <= clamp_dim(CFG_W'(RST_WIDTH));
			h_q      <= clamp_dim(CFG_W'(RST_HEIGHT));
			p_q      <= P_W'(clamp_dim(CFG_W'(RST_WIDTH)))
			          * P_W'(clamp_dim(CFG_W'(RST_HEIGHT)));
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAYOUT: begin
					layout_q <= layout_t'(cfg_data[1:0]);
				end
				REG_WIDTH: begin
					w_q <= clamp_dim(cfg_data);
					p_q <= P_W'(clamp_dim(cfg_data)) * P_W'(h_q);
				end
				REG_HEIGHT: begin
					h_q <= clamp_dim(cfg_data);
					p_q <= P_W'(w_q) * P_W'(clamp_dim(cfg_data));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (layout_q)
			LAYOUT_420: c = p_q >> 2;
			LAYOUT_422: c = p_q >> 1;
			default:    c = p_q;
		endcase
		if (layout_q == LAYOUT_UYVY) begin
			total = POS_W'({p_q, 1'b0});
		end else begin
			total = POS_W'(p_q) + POS_W'({c, 1'b0});
		end
	end

	vfpm_front #(
		.P_W   (P_W),
		.POS_W (POS_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.ref_sample  (s_axis_tdata[7:0]),
		.test_sample (s_axis_tdata[15:8]),
		.layout      (layout_q),
		.p           (p_q),
		.c           (c),
		.total       (total),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	vfpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	vfpm_back #(
		.ACC_W     (ACC_W),
		.P_W       (P_W),
		.FRAC_BITS (PSNR_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.layout    (layout_q),
		.p         (p_q),
		.c         (c),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.cr_sum, res.cb_sum, res.luma_sum,
	                       res.cr_psnr, res.cb_psnr, res.luma_psnr};
	assign m_axis_tuser = res.identical;

endmodule
